FILE: hw/rtl/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg: shared types and constants of the line edit buffer
// Word layouts, key operation codes, echo codes and cell commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package leb_pkg;

  // Line store depth, one cell per byte.
  localparam int unsigned LINE_DEPTH = 256;
  localparam int unsigned POS_W      = 8;

  // Largest cursor position a type may write: line plus terminator must fit.
  localparam logic [POS_W-1:0] TEXT_MAX = POS_W'(LINE_DEPTH - 2);

  localparam logic [6:0] CHAR_MIN   = 7'h20;
  localparam logic [7:0] CHAR_BLANK = 8'h20;

  // Key operations
  localparam logic [3:0] FUNC_TYPE   = 4'd0;
  localparam logic [3:0] FUNC_ENTER  = 4'd1;
  localparam logic [3:0] FUNC_STOP   = 4'd2;
  localparam logic [3:0] FUNC_CLEAR  = 4'd3;
  localparam logic [3:0] FUNC_BACK   = 4'd4;
  localparam logic [3:0] FUNC_LEFT   = 4'd5;
  localparam logic [3:0] FUNC_RIGHT  = 4'd6;
  localparam logic [3:0] FUNC_UP     = 4'd7;
  localparam logic [3:0] FUNC_DOWN   = 4'd8;
  localparam logic [3:0] FUNC_HOME   = 4'd9;
  localparam logic [3:0] FUNC_INSERT = 4'd10;
  localparam logic [3:0] FUNC_FETCH  = 4'd11;

  // Echo actions
  localparam logic [2:0] ECHO_NONE    = 3'd0;
  localparam logic [2:0] ECHO_CHAR    = 3'd1;
  localparam logic [2:0] ECHO_LEFT    = 3'd2;
  localparam logic [2:0] ECHO_RIGHT   = 3'd3;
  localparam logic [2:0] ECHO_BACK    = 3'd4;
  localparam logic [2:0] ECHO_INSERT  = 3'd5;
  localparam logic [2:0] ECHO_NEWLINE = 3'd6;
  localparam logic [2:0] ECHO_CLS     = 3'd7;

  // Line status
  localparam logic [1:0] STATUS_EDIT    = 2'd0;
  localparam logic [1:0] STATUS_ENTERED = 2'd1;
  localparam logic [1:0] STATUS_CANCEL  = 2'd2;

  // Configuration register indexes
  localparam logic [7:0] REG_SCREEN_WIDTH  = 8'd0;
  localparam logic [7:0] REG_LINE_CAPACITY = 8'd1;

  localparam logic [7:0] SCREEN_WIDTH_RST  = 8'd40;
  localparam logic [7:0] LINE_CAPACITY_RST = 8'd255;

  // Cell commands
  localparam logic [1:0] CMD_HOLD  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;  // load data at the cursor cell
  localparam logic [1:0] CMD_SHL   = 2'd2;  // close gap left of cursor
  localparam logic [1:0] CMD_SHR   = 2'd3;  // open gap at cursor, blank in

  typedef struct packed {
    logic [1:0]       mode;
    logic [POS_W-1:0] cursor;
    logic [POS_W-1:0] length;
    logic [7:0]       data;
  } leb_cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] key_char;
    logic [7:0] read_index;
  } leb_in_t;

  typedef struct packed {
    logic [2:0] echo_code;
    logic [7:0] echo_char;
    logic [7:0] echo_repeat;
    logic [1:0] line_status;
    logic [7:0] line_length;
    logic [7:0] read_byte;
  } leb_out_t;

endpackage

FILE: hw/rtl/leb_cell.sv
// ----------------------------------------------------------------------------
// leb_cell: one byte cell of the line store
// Holds one byte; loads, takes its left or right neighbor, and masks readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module leb_cell (
  input  logic                      clk_i,
  input  logic [leb_pkg::POS_W-1:0] cell_index_i,
  input  leb_pkg::leb_cmd_t         cmd_i,
  input  logic [7:0]                left_i,
  input  logic [7:0]                right_i,
  input  logic [7:0]                read_index_i,
  output logic [7:0]                byte_o,
  output logic [7:0]                read_o
);

  logic [7:0]              byte_q, byte_d;
  logic [leb_pkg::POS_W:0] idx_inc;

  assign idx_inc = {1'b0, cell_index_i} + 1'b1;

  always_comb begin
    byte_d = byte_q;
    case (cmd_i.mode)
      leb_pkg::CMD_WRITE: begin
        if (cell_index_i == cmd_i.cursor) byte_d = cmd_i.data;
      end
      leb_pkg::CMD_SHL: begin
        // cells cursor-1 .. length-2 pull from the right
        if (idx_inc >= {1'b0, cmd_i.cursor} && idx_inc < {1'b0, cmd_i.length}) begin
          byte_d = right_i;
        end
      end
      leb_pkg::CMD_SHR: begin
        if (cell_index_i == cmd_i.cursor) begin
          byte_d = cmd_i.data;
        end else if (cell_index_i > cmd_i.cursor && cell_index_i <= cmd_i.length) begin
          byte_d = left_i;
        end
      end
      default: byte_d = byte_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;
  assign read_o = (cell_index_i == read_index_i) ? byte_q : 8'h00;

endmodule

FILE: hw/rtl/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer: terminal line editor over a row of byte cells
// Result: an accepted key word's result word is registered, valid in the next cycle.
// Throughput: one key word per cycle unless the result side stalls; every edit,
//   shifts too, is one cell row step; the output register is the only limit.
// Reset: cursor, line length and committed length clear; screen width 40,
//   line capacity 255. Line store bytes are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_edit_buffer (
  input  logic              clk_i,
  input  logic              rst_ni,
  // key words
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  leb_pkg::leb_in_t  in_data_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output leb_pkg::leb_out_t out_data_o,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);

  localparam int unsigned DEPTH = leb_pkg::LINE_DEPTH;
  localparam int unsigned PW    = leb_pkg::POS_W;

  // --------------------------------------------------------------------------
  // Configuration registers, always writable
  // --------------------------------------------------------------------------
  logic [7:0] screen_width_q, line_capacity_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= leb_pkg::SCREEN_WIDTH_RST;
      line_capacity_q <= leb_pkg::LINE_CAPACITY_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == leb_pkg::REG_SCREEN_WIDTH)  screen_width_q  <= cfg_data_i;
      if (cfg_index_i == leb_pkg::REG_LINE_CAPACITY) line_capacity_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: output register decouples the two sides
  // --------------------------------------------------------------------------
  logic in_fire;
  logic out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Edit state
  // --------------------------------------------------------------------------
  logic [PW-1:0] cursor_q, cursor_d;
  logic [PW-1:0] len_q, len_d;
  logic [PW-1:0] comm_q, comm_d;

  // text limit: capacity-1, floored at 0, capped so the terminator fits
  logic [PW-1:0] cap_m1, text_lim;
  assign cap_m1   = (line_capacity_q == 8'd0) ? '0 : line_capacity_q - 1'b1;
  assign text_lim = (cap_m1 > leb_pkg::TEXT_MAX) ? leb_pkg::TEXT_MAX : cap_m1;

  // --------------------------------------------------------------------------
  // Cell row: each cell sees the broadcast command and both neighbors
  // --------------------------------------------------------------------------
  leb_pkg::leb_cmd_t cmd, cell_cmd;
  logic [7:0]        cell_byte [DEPTH];
  logic [7:0]        cell_read [DEPTH];
  logic [7:0]        rd_byte;

  assign cell_cmd = in_fire ? cmd : '{mode: leb_pkg::CMD_HOLD, cursor: cmd.cursor,
                                      length: cmd.length, data: cmd.data};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [7:0] left_b, right_b;
    if (g == 0) begin : g_first
      assign left_b = 8'h00;
    end else begin : g_mid_l
      assign left_b = cell_byte[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_b = 8'h00;
    end else begin : g_mid_r
      assign right_b = cell_byte[g+1];
    end

    leb_cell u_cell (
      .clk_i        (clk_i),
      .cell_index_i (PW'(g)),
      .cmd_i        (cell_cmd),
      .left_i       (left_b),
      .right_i      (right_b),
      .read_index_i (in_data_i.read_index),
      .byte_o       (cell_byte[g]),
      .read_o       (cell_read[g])
    );
  end

  // fetch: each cell masks itself by index, the row is ORed together
  always_comb begin
    rd_byte = 8'h00;
    for (int k = 0; k < DEPTH; k++) begin
      rd_byte = rd_byte | cell_read[k];
    end
  end

  // --------------------------------------------------------------------------
  // Key decode: next state, cell command and result word
  // --------------------------------------------------------------------------
  leb_pkg::leb_out_t res;
  logic [PW-1:0]     target;

  always_comb begin
    cursor_d   = cursor_q;
    len_d      = len_q;
    comm_d     = comm_q;
    target     = cursor_q;
    cmd.mode   = leb_pkg::CMD_HOLD;
    cmd.cursor = cursor_q;
    cmd.length = len_q;
    cmd.data   = in_data_i.key_char;
    res        = '0;

    case (in_data_i.func)
      leb_pkg::FUNC_TYPE: begin
        // control codes (either half) and a full line are dropped silently
        if (in_data_i.key_char[6:0] >= leb_pkg::CHAR_MIN && cursor_q <= text_lim) begin
          if (cursor_q == len_q) len_d = len_q + 1'b1;
          cmd.mode        = leb_pkg::CMD_WRITE;
          cursor_d        = cursor_q + 1'b1;
          res.echo_code   = leb_pkg::ECHO_CHAR;
          res.echo_char   = in_data_i.key_char;
          res.echo_repeat = 8'd1;
        end
      end
      leb_pkg::FUNC_ENTER: begin
        // walk the terminal cursor to the line end, then newline
        res.echo_code   = leb_pkg::ECHO_NEWLINE;
        res.echo_repeat = len_q - cursor_q;
        res.line_status = leb_pkg::STATUS_ENTERED;
        comm_d          = len_q;
        cursor_d        = '0;
        len_d           = '0;
      end
      leb_pkg::FUNC_STOP: begin
        res.echo_code   = leb_pkg::ECHO_NEWLINE;
        res.line_status = leb_pkg::STATUS_CANCEL;
        comm_d          = '0;
        cursor_d        = '0;
        len_d           = '0;
      end
      leb_pkg::FUNC_CLEAR: begin
        res.echo_code   = leb_pkg::ECHO_CLS;
        res.echo_repeat = 8'd1;
        cursor_d        = '0;
        len_d           = '0;
      end
      leb_pkg::FUNC_BACK: begin
        if (cursor_q != '0) begin
          cmd.mode        = leb_pkg::CMD_SHL;
          len_d           = len_q - 1'b1;
          cursor_d        = cursor_q - 1'b1;
          res.echo_code   = leb_pkg::ECHO_BACK;
          res.echo_repeat = 8'd1;
        end
      end
      leb_pkg::FUNC_LEFT: begin
        if (cursor_q != '0) begin
          cursor_d        = cursor_q - 1'b1;
          res.echo_code   = leb_pkg::ECHO_LEFT;
          res.echo_repeat = 8'd1;
        end
      end
      leb_pkg::FUNC_RIGHT: begin
        if (cursor_q < len_q) begin
          cursor_d        = cursor_q + 1'b1;
          res.echo_code   = leb_pkg::ECHO_RIGHT;
          res.echo_repeat = 8'd1;
        end
      end
      leb_pkg::FUNC_UP: begin
        target          = (cursor_q > screen_width_q) ? cursor_q - screen_width_q : '0;
        cursor_d        = target;
        res.echo_repeat = cursor_q - target;
        if (cursor_q != target) res.echo_code = leb_pkg::ECHO_LEFT;
      end
      leb_pkg::FUNC_DOWN: begin
        // stays within the line, so the sum never wraps
        target          = ((len_q - cursor_q) > screen_width_q) ?
                          cursor_q + screen_width_q : len_q;
        cursor_d        = target;
        res.echo_repeat = target - cursor_q;
        if (cursor_q != target) res.echo_code = leb_pkg::ECHO_RIGHT;
      end
      leb_pkg::FUNC_HOME: begin
        cursor_d        = '0;
        res.echo_repeat = cursor_q;
        if (cursor_q != '0) res.echo_code = leb_pkg::ECHO_LEFT;
      end
      leb_pkg::FUNC_INSERT: begin
        // needs room for one more byte and a tail to push
        if (len_q <= text_lim && cursor_q != len_q) begin
          cmd.mode        = leb_pkg::CMD_SHR;
          cmd.data        = leb_pkg::CHAR_BLANK;
          len_d           = len_q + 1'b1;
          res.echo_code   = leb_pkg::ECHO_INSERT;
          res.echo_repeat = 8'd1;
        end
      end
      leb_pkg::FUNC_FETCH: begin
        if (in_data_i.read_index < comm_q) res.read_byte = rd_byte;
      end
      default: res = '0;
    endcase

    // enter, stop and fetch report the committed length
    if (in_data_i.func == leb_pkg::FUNC_ENTER || in_data_i.func == leb_pkg::FUNC_STOP ||
        in_data_i.func == leb_pkg::FUNC_FETCH) begin
      res.line_length = comm_d;
    end else begin
      res.line_length = len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      len_q       <= '0;
      comm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        cursor_q <= cursor_d;
        len_q    <= len_d;
        comm_q   <= comm_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted key word
  leb_pkg::leb_out_t out_data_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hw/rtl/leb_checker.sv
// ----------------------------------------------------------------------------
// leb_checker: port-level checks of the line edit buffer
// Watches the ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module leb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input leb_pkg::leb_out_t out_data_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // every accepted key word shows up as a result on the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("result word missing after accept");

  // a committed or cancelled line always echoes a newline
  a_commit_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_status != leb_pkg::STATUS_EDIT |->
      out_data_o.echo_code == leb_pkg::ECHO_NEWLINE)
    else $error("line status without newline echo");

  // no action means no repeats
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.echo_code == leb_pkg::ECHO_NONE |->
      out_data_o.echo_repeat == 8'd0)
    else $error("repeat count on empty echo");

  // a cancelled line has no length
  a_cancel_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_status == leb_pkg::STATUS_CANCEL |->
      out_data_o.line_length == 8'd0)
    else $error("cancelled line reports a length");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);
